// ----- sv/wchc_pkg.sv -----
`default_nettype none

package wchc_pkg;

   localparam int ACC_W      = 40;
   localparam int FRAC_BITS  = 32;
   localparam int FRAC_W     = FRAC_BITS + 1;
   localparam int WGT_W      = 16;
   localparam int CH_W       = 8;
   localparam int IDX_W      = 15;
   localparam int WIDE_IDX_W = 3 * CH_W;
   localparam int SHIFT_W    = 3;
   localparam int KIND_W     = 2;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [ACC_W-1:0] ACC_MAX = '1;

   // request codes
   localparam logic [KIND_W-1:0] REQ_ACCUM = 2'd0;
   localparam logic [KIND_W-1:0] REQ_READ  = 2'd1;
   localparam logic [KIND_W-1:0] REQ_CLEAR = 2'd2;

   // register word indexes
   localparam logic [CSR_ADDR_W-3:0] CSR_BIN_SHIFT = 1'b0;

   localparam logic [SHIFT_W-1:0] BIN_SHIFT_RESET = 3'd3;

   typedef struct packed {
      logic [KIND_W-1:0] req_type;
      logic [CH_W-1:0]   red;
      logic [CH_W-1:0]   green;
      logic [CH_W-1:0]   blue;
      logic [WGT_W-1:0]  weight;
      logic [IDX_W-1:0]  bin_index;
   } req_payload_type;

   typedef struct packed {
      logic [FRAC_W-1:0] bin_fraction;
      logic              zero_total;
   } rsp_payload_type;

   typedef struct packed {
      logic start;
      logic zero;
      logic take;
   } div_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

// ----- sv/wchc_frac_div.sv -----
`default_nettype none

module wchc_frac_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire wchc_pkg::div_cmd_type      cmd,
   input  wire logic [wchc_pkg::ACC_W-1:0] num,
   input  wire logic [wchc_pkg::ACC_W-1:0] den,
   output wchc_pkg::div_status_type        status,
   output wchc_pkg::rsp_payload_type       result
);
   import wchc_pkg::*;

   localparam int STEP_W = $clog2(FRAC_BITS);

   typedef enum logic [2:0] {
      DIV_IDLE = 3'b001,
      DIV_RUN  = 3'b010,
      DIV_DONE = 3'b100
   } div_state_type;

   div_state_type       state_ff, state_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [ACC_W-1:0]    rem_ff, rem_in;
   logic [ACC_W-1:0]    den_ff, den_in;
   logic [FRAC_W-1:0]   quo_ff, quo_in;
   logic                zero_ff, zero_in;
   logic [ACC_W:0]      rem_dbl;
   logic [ACC_W:0]      rem_sub;
   logic                fits;
   logic                first_bit;

   // restoring division, one quotient bit a cycle
   always_comb begin
      rem_dbl   = {rem_ff, 1'b0};
      rem_sub   = rem_dbl - {1'b0, den_ff};
      fits      = rem_dbl >= {1'b0, den_ff};
      first_bit = num >= den;
      state_in  = state_ff;
      step_in   = step_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      quo_in    = quo_ff;
      zero_in   = zero_ff;
      unique case (state_ff)
         DIV_IDLE: begin
            if (cmd.start) begin
               den_in  = den;
               zero_in = cmd.zero;
               step_in = '0;
               if (cmd.zero) begin
                  quo_in   = '0;
                  rem_in   = '0;
                  state_in = DIV_DONE;
               end else begin
                  quo_in   = {{FRAC_BITS{1'b0}}, first_bit};
                  rem_in   = first_bit ? '0 : num;
                  state_in = DIV_RUN;
               end
            end
         end
         DIV_RUN: begin
            rem_in  = fits ? rem_sub[ACC_W-1:0] : rem_dbl[ACC_W-1:0];
            quo_in  = {quo_ff[FRAC_W-2:0], fits};
            step_in = step_ff + 1'b1;
            if (&step_ff) begin
               state_in = DIV_DONE;
            end
         end
         DIV_DONE: begin
            if (cmd.take) begin
               state_in = DIV_IDLE;
            end
         end
         default: begin
            state_in = DIV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
      zero_ff <= zero_in;
   end

   assign status.busy          = (state_ff != DIV_IDLE);
   assign status.done          = (state_ff == DIV_DONE);
   assign result.bin_fraction  = quo_ff;
   assign result.zero_total    = zero_ff;

endmodule

`default_nettype wire

// ----- sv/weighted_color_histogram_cube_top.sv -----
// weighted 3d color histogram over a cube of bins held in one on-chip memory
//
// req channel (valid/stall) carries one request per transfer:
//   accumulate: pixel red/green/blue are shifted right by the effective shift
//     and the weight is added (saturating) to that bin and to the total;
//     one pixel per cycle, back to back, while req_stall is low; same-bin repeats are forwarded
//   read: returns bin / total as an unsigned Q1.32 fraction on rsp, after the
//     memory read, a divider setup step, the one-bit-per-cycle divider steps and
//     the output register; a zero total skips the divider steps and answers
//     with zero_total set
//   clear: zeroes bins and total by sweeping the memory one entry per cycle
//     over all 2**(3*SIDE_BITS) entries (32768 at the default), req_stall high meanwhile
// after reset the same clearing sweep runs before the first request is taken;
// csr writes (bin_shift) are taken at any time, also during the sweep
// rsp has an output register: while it holds a result under rsp_stall, new
// accumulates still flow; the next read waits in the divider until rsp frees
// accumulate and read share the read-modify-write stage, so order is kept
`default_nettype none

module weighted_color_histogram_cube_top #(
   parameter int SIDE_BITS = 5
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire wchc_pkg::req_payload_type           req_payload,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output wchc_pkg::rsp_payload_type                rsp_payload,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [wchc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [wchc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [wchc_pkg::CSR_DATA_W-1:0]          csr_prdata,
   output logic                                     csr_pready
);
   import wchc_pkg::*;

   localparam int ADDR_W = 3 * SIDE_BITS;
   localparam int DEPTH  = 1 << ADDR_W;
   localparam logic [SHIFT_W-1:0] MIN_SHIFT = SHIFT_W'(CH_W - SIDE_BITS);

   // histogram store, no reset: cleared by the sweep
   logic [ACC_W-1:0]        bins_mem [DEPTH];
   logic [ACC_W-1:0]        rdata_ff;

   // configuration
   logic [SHIFT_W-1:0]      bin_shift_ff, bin_shift_in;
   logic                    csr_write;

   // request decode
   logic                    req_accept;
   logic [SHIFT_W-1:0]      eff_shift;
   logic [3:0]              side_bits;
   logic [5:0]              cube_bits;
   logic [CH_W-1:0]         red_bin, green_bin, blue_bin;
   logic [WIDE_IDX_W-1:0]   pix_idx;
   logic [WIDE_IDX_W-1:0]   read_idx;
   logic                    read_in_range;
   logic [ADDR_W-1:0]       rd_addr;
   logic                    take_item;

   // read-modify-write stage
   logic                    p_valid_ff, p_valid_in;
   logic [KIND_W-1:0]       p_kind_ff;
   logic [ADDR_W-1:0]       p_addr_ff;
   logic [WGT_W-1:0]        p_weight_ff;
   logic                    p_in_range_ff;
   logic [ACC_W-1:0]        bin_base;
   logic [ACC_W:0]          bin_sum, total_sum;
   logic [ACC_W-1:0]        bin_new, total_new;
   logic                    p_accum, p_read, p_clear;

   // last write, for a back-to-back hit on the same bin
   logic                    fwd_valid_ff, fwd_valid_in;
   logic [ADDR_W-1:0]       fwd_addr_ff;
   logic [ACC_W-1:0]        fwd_data_ff;

   logic [ACC_W-1:0]        total_ff, total_in;

   // clearing sweep
   logic                    sweep_ff, sweep_in;
   logic [ADDR_W-1:0]       sweep_cnt_ff, sweep_cnt_in;

   // memory write port
   logic                    wr_en;
   logic [ADDR_W-1:0]       wr_addr;
   logic [ACC_W-1:0]        wr_data;

   // divider and output register
   div_cmd_type             div_cmd;
   div_status_type          div_status;
   rsp_payload_type         div_result;
   logic [ACC_W-1:0]        div_num;
   logic                    rsp_load;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_payload_type         rsp_payload_ff;

   //------------------------------------------------------------------
   // csr port, single word register
   //------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready
                       & (csr_paddr[CSR_ADDR_W-1:2] == CSR_BIN_SHIFT);

   always_comb begin
      bin_shift_in = bin_shift_ff;
      if (csr_write) begin
         bin_shift_in = csr_pwdata[SHIFT_W-1:0];
      end
      csr_prdata = '0;
      if (csr_paddr[CSR_ADDR_W-1:2] == CSR_BIN_SHIFT) begin
         csr_prdata = {{(CSR_DATA_W-SHIFT_W){1'b0}}, bin_shift_ff};
      end
   end

   //------------------------------------------------------------------
   // request decode and bin address
   //------------------------------------------------------------------
   // reads and clears hold the channel until the divider or sweep takes over
   assign req_stall  = sweep_ff | div_status.busy
                       | (p_valid_ff & (p_read | p_clear));
   assign req_accept = req_valid & ~req_stall;

   always_comb begin
      // shift never goes below what keeps the cube inside the store
      eff_shift = (bin_shift_ff < MIN_SHIFT) ? MIN_SHIFT : bin_shift_ff;
      side_bits = 4'(CH_W) - {1'b0, eff_shift};
      cube_bits = {2'b0, side_bits} + {1'b0, side_bits, 1'b0};
      red_bin   = req_payload.red   >> eff_shift;
      green_bin = req_payload.green >> eff_shift;
      blue_bin  = req_payload.blue  >> eff_shift;
      pix_idx   = ({{(WIDE_IDX_W-CH_W){1'b0}}, blue_bin} << {side_bits, 1'b0})
                | ({{(WIDE_IDX_W-CH_W){1'b0}}, green_bin} << side_bits)
                |  {{(WIDE_IDX_W-CH_W){1'b0}}, red_bin};
      read_idx  = {{(WIDE_IDX_W-IDX_W){1'b0}}, req_payload.bin_index};
      // an index past the cube reads as an empty bin
      read_in_range = ((read_idx >> cube_bits) == '0);
      rd_addr   = (req_payload.req_type == REQ_READ) ? read_idx[ADDR_W-1:0]
                                                     : pix_idx[ADDR_W-1:0];
      // zero-weight pixels and unknown codes are dropped at the door
      take_item = 1'b0;
      unique case (req_payload.req_type) inside
         REQ_ACCUM:            take_item = (req_payload.weight != '0);
         REQ_READ, REQ_CLEAR:  take_item = 1'b1;
         default:              take_item = 1'b0;
      endcase
   end

   //------------------------------------------------------------------
   // read-modify-write stage
   //------------------------------------------------------------------
   assign p_accum = (p_kind_ff == REQ_ACCUM);
   assign p_read  = (p_kind_ff == REQ_READ);
   assign p_clear = (p_kind_ff == REQ_CLEAR);

   always_comb begin
      // the memory read misses a write at the same edge, forward it
      bin_base  = (fwd_valid_ff && (fwd_addr_ff == p_addr_ff)) ? fwd_data_ff : rdata_ff;
      bin_sum   = {1'b0, bin_base} + {{(ACC_W+1-WGT_W){1'b0}}, p_weight_ff};
      total_sum = {1'b0, total_ff} + {{(ACC_W+1-WGT_W){1'b0}}, p_weight_ff};
      bin_new   = bin_sum[ACC_W]   ? ACC_MAX : bin_sum[ACC_W-1:0];
      total_new = total_sum[ACC_W] ? ACC_MAX : total_sum[ACC_W-1:0];

      p_valid_in = req_accept & take_item;

      wr_en   = 1'b0;
      wr_addr = p_addr_ff;
      wr_data = bin_new;
      if (sweep_ff) begin
         wr_en   = 1'b1;
         wr_addr = sweep_cnt_ff;
         wr_data = '0;
      end else if (p_valid_ff && p_accum) begin
         wr_en = 1'b1;
      end

      fwd_valid_in = fwd_valid_ff;
      if (sweep_ff) begin
         fwd_valid_in = 1'b0;
      end else if (p_valid_ff && p_accum) begin
         fwd_valid_in = 1'b1;
      end

      total_in = total_ff;
      if (sweep_ff) begin
         total_in = '0;
      end else if (p_valid_ff && p_accum) begin
         total_in = total_new;
      end

      sweep_in     = sweep_ff;
      sweep_cnt_in = sweep_cnt_ff;
      if (sweep_ff) begin
         sweep_cnt_in = sweep_cnt_ff + 1'b1;
         if (&sweep_cnt_ff) begin
            sweep_in = 1'b0;
         end
      end else if (p_valid_ff && p_clear) begin
         sweep_in     = 1'b1;
         sweep_cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         bins_mem[wr_addr] <= wr_data;
      end
      if (req_accept) begin
         rdata_ff <= bins_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         p_kind_ff     <= req_payload.req_type;
         p_addr_ff     <= rd_addr;
         p_weight_ff   <= req_payload.weight;
         p_in_range_ff <= read_in_range;
      end
      if (p_valid_ff && p_accum) begin
         fwd_addr_ff <= p_addr_ff;
         fwd_data_ff <= bin_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_shift_ff <= BIN_SHIFT_RESET;
         p_valid_ff   <= 1'b0;
         fwd_valid_ff <= 1'b0;
         total_ff     <= '0;
         sweep_ff     <= 1'b1;
         sweep_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bin_shift_ff <= bin_shift_in;
         p_valid_ff   <= p_valid_in;
         fwd_valid_ff <= fwd_valid_in;
         total_ff     <= total_in;
         sweep_ff     <= sweep_in;
         sweep_cnt_ff <= sweep_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   //------------------------------------------------------------------
   // fraction divider and output register
   //------------------------------------------------------------------
   assign div_num       = p_in_range_ff ? bin_base : '0;
   assign rsp_load      = div_status.done & (~rsp_valid_ff | ~rsp_stall);
   assign div_cmd.start = p_valid_ff & p_read;
   assign div_cmd.zero  = (total_ff == '0);
   assign div_cmd.take  = rsp_load;

   wchc_frac_div u_frac_div (
      .clock  (clock),
      .reset  (reset),
      .cmd    (div_cmd),
      .num    (div_num),
      .den    (total_ff),
      .status (div_status),
      .result (div_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_payload_ff <= div_result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef SYNTHESIS
   // sweep and pipeline never write the store together
   a_sweep_excl: assert property (@(posedge clock) disable iff (reset)
      !(sweep_ff && p_valid_ff))
      else $error("pipeline item present during clearing sweep");

   // a clear in the pipeline starts the sweep
   a_clear_sweep: assert property (@(posedge clock) disable iff (reset)
      (p_valid_ff && p_clear) |=> sweep_ff)
      else $error("clear did not start the sweep");

   // the divider is only started when idle
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_cmd.start |-> !div_status.busy)
      else $error("divider started while busy");

   // fraction never above one
   a_frac_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_payload.bin_fraction[FRAC_BITS]
                      && (rsp_payload.bin_fraction[FRAC_BITS-1:0] != '0)))
      else $error("fraction above one");

   // a zero total gives a zero fraction
   a_zero_total: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.zero_total) |-> (rsp_payload.bin_fraction == '0))
      else $error("nonzero fraction with zero total");
`endif

endmodule

`default_nettype wire

// ----- dv/weighted_color_histogram_cube_top_test.sv -----
`timescale 1ns / 100ps

module weighted_color_histogram_cube_top_test;

   import wchc_pkg::*;

   localparam int SIDE_BITS    = 5;
   localparam int STORE_DEPTH  = 1 << (3 * SIDE_BITS);
   // settle margin after the last read is back, before a csr write
   localparam int DRAIN_CYCLES = 40;
   // six full-store clearing sweeps plus reads under long stalls, several times over
   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int RECENT_DEPTH = 32;

   // request code the block has to drop without a result
   localparam logic [KIND_W-1:0] REQ_UNKNOWN = 2'd3;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   req_payload_type         req_payload;
   logic                    rsp_valid;
   logic                    rsp_stall;
   rsp_payload_type         rsp_payload;
   logic                    csr_psel;
   logic                    csr_penable;
   logic                    csr_pwrite;
   logic [CSR_ADDR_W-1:0]   csr_paddr;
   logic [CSR_DATA_W-1:0]   csr_pwdata;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   // histogram mirror: bin sums, running total and the shift in force
   logic [ACC_W-1:0]        bin_sums [int unsigned];
   logic [ACC_W-1:0]        total_sum;
   logic [SHIFT_W-1:0]      hist_shift;
   int unsigned             recent_bins[$];
   rsp_payload_type         expected_fractions[$];

   int                      failures;
   bit                      req_gaps_on;
   bit                      rsp_stall_on;
   int unsigned             hold_cycles_req;
   bit                      hold_active;

   weighted_color_histogram_cube_top #(
      .SIDE_BITS(SIDE_BITS)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // histogram prediction
   // ------------------------------------------------------------------

   // bits per cube side; shifts below the store limit act as the limit
   function automatic int unsigned cube_side_bits();
      int unsigned eff;
      eff = (hist_shift < CH_W - SIDE_BITS) ? CH_W - SIDE_BITS : hist_shift;
      return CH_W - eff;
   endfunction

   function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] acc,
                                                input logic [WGT_W-1:0] w);
      logic [ACC_W:0] sum;
      sum = {1'b0, acc} + {{(ACC_W+1-WGT_W){1'b0}}, w};
      return sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
   endfunction

   function automatic logic [ACC_W-1:0] stored_bin(input int unsigned idx);
      return bin_sums.exists(idx) ? bin_sums[idx] : '0;
   endfunction

   // update the mirror with one accepted request, queue the fraction of a read
   task automatic apply_request(input req_payload_type req);
      int unsigned                sb;
      int unsigned                idx;
      logic [ACC_W-1:0]           bw;
      logic [ACC_W+FRAC_BITS-1:0] scaled;
      rsp_payload_type            rsp;
      sb = cube_side_bits();
      case (req.req_type)
         REQ_ACCUM: begin
            // zero weight leaves bins and total alone
            if (req.weight != '0) begin
               idx = ((32'(req.blue) >> (CH_W - sb)) << (2 * sb))
                   | ((32'(req.green) >> (CH_W - sb)) << sb)
                   | (32'(req.red) >> (CH_W - sb));
               idx &= STORE_DEPTH - 1;
               bin_sums[idx] = sat_add(stored_bin(idx), req.weight);
               total_sum = sat_add(total_sum, req.weight);
               recent_bins.push_back(idx);
               if (recent_bins.size() > RECENT_DEPTH)
                  void'(recent_bins.pop_front());
            end
         end
         REQ_READ: begin
            idx = 32'(req.bin_index);
            // an index outside the current cube reads as an empty bin
            bw = (idx < (32'd1 << (3 * sb))) ? stored_bin(idx) : '0;
            if (total_sum == '0) begin
               rsp.bin_fraction = '0;
               rsp.zero_total   = 1'b1;
            end else begin
               if (bw > total_sum)
                  bw = total_sum;
               scaled = {bw, {FRAC_BITS{1'b0}}} / total_sum;
               rsp.bin_fraction = scaled[FRAC_W-1:0];
               rsp.zero_total   = 1'b0;
            end
            expected_fractions.push_back(rsp);
         end
         REQ_CLEAR: begin
            bin_sums.delete();
            total_sum = '0;
            recent_bins.delete();
         end
         default: begin
         end
      endcase
   endtask

   // ------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------

   task automatic idle_requests(input int unsigned cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // one transfer on req, then a random gap when gaps are enabled
   task automatic send_request(input req_payload_type req);
      int unsigned pick;
      int unsigned gap;
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= req;
      do @(posedge clock); while (req_stall);
      apply_request(req);
      gap = 0;
      if (req_gaps_on) begin
         pick = $urandom_range(0, 99);
         if (pick >= 93)
            gap = $urandom_range(15, 40);
         else if (pick >= 65)
            gap = $urandom_range(1, 3);
      end
      if (gap != 0)
         idle_requests(gap);
   endtask

   // unused fields carry random bits too, the block must ignore them
   function automatic req_payload_type random_request(input logic [KIND_W-1:0] kind);
      req_payload_type req;
      req.req_type  = kind;
      req.red       = CH_W'($urandom);
      req.green     = CH_W'($urandom);
      req.blue      = CH_W'($urandom);
      req.weight    = WGT_W'($urandom);
      req.bin_index = IDX_W'($urandom);
      return req;
   endfunction

   task automatic send_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                             input logic [CH_W-1:0] b, input logic [WGT_W-1:0] w);
      req_payload_type req;
      req        = random_request(REQ_ACCUM);
      req.red    = r;
      req.green  = g;
      req.blue   = b;
      req.weight = w;
      send_request(req);
   endtask

   task automatic send_read(input logic [IDX_W-1:0] idx);
      req_payload_type req;
      req           = random_request(REQ_READ);
      req.bin_index = idx;
      send_request(req);
   endtask

   task automatic send_kind(input logic [KIND_W-1:0] kind);
      send_request(random_request(kind));
   endtask

   // sender pauses until all reads are back and any clear sweep is over
   task automatic drain_block();
      idle_requests(1);
      while (expected_fractions.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // csr side
   // ------------------------------------------------------------------

   // setup phase then access phase, data taken at the edge with pready high
   task automatic csr_access(input logic write, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // only written with the block idle, then read back
   task automatic write_bin_shift(input logic [SHIFT_W-1:0] value);
      logic [CSR_ADDR_W-1:0] addr;
      logic [CSR_DATA_W-1:0] readback;
      addr = {CSR_BIN_SHIFT, 2'b00};
      drain_block();
      csr_access(1'b1, addr, CSR_DATA_W'(value), readback);
      hist_shift = value;
      recent_bins.delete();
      csr_access(1'b0, addr, '0, readback);
      if (readback !== CSR_DATA_W'(value)) begin
         $error("bin_shift readback: expected %0d, actual %0d", value, readback);
         failures++;
      end
   endtask

   // ------------------------------------------------------------------
   // result side
   // ------------------------------------------------------------------

   // each rsp transfer is matched against the oldest pending read
   always @(posedge clock) begin : result_check
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_fractions.size() == 0) begin
            $error("result with no read pending: bin_fraction %0h zero_total %0b",
                   rsp_payload.bin_fraction, rsp_payload.zero_total);
            failures++;
         end else begin
            want = expected_fractions.pop_front();
            if (rsp_payload.bin_fraction !== want.bin_fraction) begin
               $error("bin_fraction: expected %0h, actual %0h",
                      want.bin_fraction, rsp_payload.bin_fraction);
               failures++;
            end
            if (rsp_payload.zero_total !== want.zero_total) begin
               $error("zero_total: expected %0b, actual %0b",
                      want.zero_total, rsp_payload.zero_total);
               failures++;
            end
         end
      end
   end

   // receiver stalls: mostly short runs, some long ones, plus a requested hold
   initial begin : rsp_stall_driver
      int unsigned pick;
      int unsigned len;
      bit          level;
      rsp_stall = 1'b0;
      forever begin
         if (hold_cycles_req != 0) begin
            level           = 1'b1;
            len             = hold_cycles_req;
            hold_cycles_req = 0;
            hold_active     = 1'b1;
         end else if (!rsp_stall_on) begin
            level = 1'b0;
            len   = 1;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               level = 1'b0;
               len   = $urandom_range(1, 8);
            end else if (pick < 95) begin
               level = 1'b1;
               len   = $urandom_range(1, 4);
            end else begin
               level = 1'b1;
               len   = $urandom_range(20, 60);
            end
         end
         @(negedge clock);
         rsp_stall <= level;
         repeat (len - 1) @(negedge clock);
         hold_active = 1'b0;
      end
   end

   // run limit
   initial begin : watchdog
      int unsigned cycles;
      for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clock);
      $display("Some tests failed");
      $finish;
   end

   // ------------------------------------------------------------------
   // directed tests
   // ------------------------------------------------------------------

   // nothing accumulated yet, and a zero weight must not count
   task automatic test_zero_total();
      write_bin_shift(BIN_SHIFT_RESET);
      send_read(15'd0);
      send_pixel(8'hFF, 8'hFF, 8'hFF, 16'h0000);
      send_read(15'h7FFF);
   endtask

   // all weight in one corner bin gives a fraction of exactly one
   task automatic test_whole_bin();
      send_pixel(8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
      send_read(15'h7FFF);
      send_read(15'd0);
   endtask

   // weight split over opposite corners and a middle bin
   task automatic test_separate_bins();
      send_pixel(8'h00, 8'h00, 8'h00, 16'h0001);
      send_pixel(8'd8, 8'd16, 8'd24, 16'h8000);
      send_read(15'd0);
      send_read(15'd3137);
      send_read(15'h7FFF);
   endtask

   task automatic test_ignored_request();
      send_kind(REQ_UNKNOWN);
      send_read(15'd0);
   endtask

   // widest shift gives a 2x2x2 cube, older bins stay; a too-small shift is clamped
   task automatic test_shift_settings();
      write_bin_shift(3'd7);
      send_pixel(8'hFF, 8'h00, 8'h80, 16'h1234);
      send_read(15'd5);
      send_read(15'd8);
      send_read(15'h7FFF);
      send_read(15'd0);
      write_bin_shift(3'd0);
      send_pixel(8'hFF, 8'hFF, 8'hFF, 16'h0001);
      send_read(15'h7FFF);
   endtask

   task automatic test_clear();
      send_kind(REQ_CLEAR);
      send_read(15'h7FFF);
   endtask

   // receiver holds off long enough for reads to back up and stall req
   task automatic test_stall_fill();
      int unsigned n;
      logic [23:0] color;
      drain_block();
      req_gaps_on     = 1'b0;
      hold_cycles_req = 300;
      wait (hold_active);
      color = 24'($urandom);
      for (n = 0; n < 40; n++) begin
         if (n % 2 == 0)
            send_pixel(color[23:16], color[15:8], color[7:0], WGT_W'($urandom));
         else
            send_read(recent_bins.size() != 0 ? IDX_W'(recent_bins[0]) : 15'd0);
      end
      drain_block();
   endtask

   // ------------------------------------------------------------------
   // random traffic: phases over shift settings, a palette keeps bins busy
   // ------------------------------------------------------------------

   task automatic test_random_pixels();
      logic [SHIFT_W-1:0] shifts [8] = '{3'd7, 3'd4, 3'd1, 3'd6, 3'd3, 3'd5, 3'd2, 3'd7};
      logic [23:0]        palette [8];
      logic [23:0]        color;
      logic [WGT_W-1:0]   w;
      logic [IDX_W-1:0]   idx;
      int unsigned        ph;
      int unsigned        k;
      int unsigned        n;
      int unsigned        pick;
      int unsigned        sel;
      for (ph = 0; ph < 8; ph++) begin
         write_bin_shift(shifts[ph]);
         // some phases run back to back on one side or both
         req_gaps_on  = (ph % 3 != 1);
         rsp_stall_on = (ph % 4 != 2);
         for (k = 0; k < 8; k++)
            palette[k] = 24'($urandom);
         if (ph % 2 == 1)
            send_kind(REQ_CLEAR);
         for (n = 0; n < 75; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
               color = (pick < 40) ? palette[$urandom_range(0, 7)] : 24'($urandom);
               sel   = $urandom_range(0, 9);
               if (sel == 0)
                  w = '0;
               else if (sel == 1)
                  w = '1;
               else
                  w = WGT_W'($urandom);
               send_pixel(color[23:16], color[15:8], color[7:0], w);
            end else if (pick < 94) begin
               sel = $urandom_range(0, 9);
               if (sel < 6 && recent_bins.size() != 0)
                  idx = IDX_W'(recent_bins[$urandom_range(0, recent_bins.size() - 1)]);
               else if (sel < 8)
                  idx = IDX_W'($urandom_range(0, (1 << (3 * cube_side_bits())) - 1));
               else
                  idx = IDX_W'($urandom_range(0, STORE_DEPTH - 1));
               send_read(idx);
            end else begin
               send_kind(REQ_UNKNOWN);
            end
         end
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      failures    = 0;
      total_sum   = '0;
      hist_shift  = BIN_SHIFT_RESET;
      req_gaps_on = 1'b1;
      rsp_stall_on    = 1'b1;
      hold_cycles_req = 0;
      hold_active     = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_zero_total();
      test_whole_bin();
      test_separate_bins();
      test_ignored_request();
      test_shift_settings();
      test_clear();
      test_stall_fill();
      test_random_pixels();

      drain_block();
      if (failures == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
